// ===== design/strs_pkg.sv =====
// Shared types and constants for the segment tree range-sum block.
`default_nettype none

package strs_pkg;

    // Field widths fixed by the block's interface.
    localparam int COUNT_W = 11;
    localparam int DATA_W  = 64;

    // Default tree capacity and the reset value of the element count.
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Request kinds.
    localparam logic KIND_SET   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_LEAF,
        ST_SET_UP,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_DONE
    } strs_state_t;

endpackage

`default_nettype wire

// ===== design/strs_ifs.sv =====
// Request and response channel interfaces for the segment tree range-sum block.
`default_nettype none

interface strs_req_if
    import strs_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [COUNT_W-1:0]        position;
    logic signed [DATA_W-1:0]  new_value;
    logic [COUNT_W-1:0]        range_left;
    logic [COUNT_W-1:0]        range_right;

    modport source (output valid, kind, position, new_value, range_left, range_right,
                    input ready);
    modport sink   (input valid, kind, position, new_value, range_left, range_right,
                    output ready);
endinterface

interface strs_rsp_if
    import strs_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface

`default_nettype wire

// ===== design/segment_tree_range_sum.sv =====
// Point-update, range-sum segment tree held in one synchronous node memory.
//
//   channel   dir   handshake       payload
//   req       in    valid/ready     kind, position, new_value, range_left, range_right
//   rsp       out   valid/ready     range_sum
//   cfg       in    cfg_wr_en       cfg_wr_data (element_count)
//
// After reset a clearing pass zeroes the 2*MAX_ELEMENTS node words, one per cycle;
// no request is taken during the clearing pass.
// A set request walks leaf to root at one node per cycle, as the memory has a single
// read port and a single write port.
// A query issues at most one memory read per cycle and passes through ST_Q_LEFT
// and ST_Q_RIGHT for each tree level.
// The result register frees the sequencer; a query waits only if the previous
// result has not been taken yet.
`default_nettype none

module segment_tree_range_sum
    import strs_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    strs_req_if.sink                req,
    strs_rsp_if.source              rsp
);

    // Node index widths: NW addresses the memory, LW also holds 2*MAX_ELEMENTS.
    localparam int NW    = $clog2(2 * MAX_ELEMENTS);
    localparam int LW    = NW + 1;
    localparam int CW    = (LW > COUNT_W) ? LW : COUNT_W;
    localparam int DEPTH = 2 * MAX_ELEMENTS;
    localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);
    localparam logic [NW-1:0] LEAF_BASE = NW'(MAX_ELEMENTS);
    localparam logic [LW-1:0] LEAF_BASE_L = LW'(MAX_ELEMENTS);
    localparam logic [CW-1:0] CAP_C = CW'(MAX_ELEMENTS);

    // Node memory.
    logic [DATA_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic [NW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [NW-1:0]     mem_raddr;
    logic [DATA_W-1:0] rd_data_reg;

    // Sequencer and datapath registers.
    strs_state_t       state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [NW-1:0]     clr_reg, clr_next;
    logic [NW-1:0]     node_reg, node_next;
    logic [LW-1:0]     l_reg, l_next;
    logic [LW-1:0]     r_reg, r_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] diff_reg, diff_next;
    logic [DATA_W-1:0] newv_reg, newv_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_sum_reg, out_sum_next;

    // Request decode signals.
    logic [CW-1:0]     n_eff;
    logic [CW-1:0]     pos_c;
    logic              set_ok;
    logic [CW-1:0]     lo_c;
    logic [CW-1:0]     hi_c;
    logic              q_empty;
    logic [NW-1:0]     leaf_idx;
    logic [LW-1:0]     l_init;
    logic [LW-1:0]     r_init;

    // Memory port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Element count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    // Clipping of positions against the effective count and leaf addressing.
    always_comb
    begin
        n_eff    = (CW'(count_reg) > CAP_C) ? CAP_C : CW'(count_reg);
        pos_c    = CW'(req.position);
        set_ok   = (pos_c != '0) && (pos_c <= n_eff);
        lo_c     = (req.range_left == '0) ? CW'(1) : CW'(req.range_left);
        hi_c     = (CW'(req.range_right) > n_eff) ? n_eff : CW'(req.range_right);
        q_empty  = lo_c > hi_c;
        leaf_idx = LEAF_BASE + NW'(req.position) - NW'(1);
        l_init   = LEAF_BASE_L + LW'(lo_c) - LW'(1);
        r_init   = LEAF_BASE_L + LW'(hi_c);
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            node_reg      <= '0;
        end
        else
        begin
            clr_reg       <= clr_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            node_reg      <= node_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        l_reg       <= l_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        diff_reg    <= diff_next;
        newv_reg    <= newv_next;
        out_sum_reg <= out_sum_next;
    end

    // Next state, memory control and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = rd_pend_reg ? (acc_reg + rd_data_reg) : acc_reg;
        diff_next      = diff_reg;
        newv_next      = newv_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_sum_next   = out_sum_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = node_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.kind == KIND_QUERY)
                    begin
                        l_next     = q_empty ? '0 : l_init;
                        r_next     = q_empty ? '0 : r_init;
                        acc_next   = '0;
                        state_next = ST_Q_LEFT;
                    end
                    else if (set_ok)
                    begin
                        node_next  = leaf_idx;
                        newv_next  = req.new_value;
                        state_next = ST_SET_RD;
                    end
                end
            end
            ST_SET_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SET_LEAF;
            end
            ST_SET_LEAF:
            begin
                // Leaf takes the new value; the difference rides up the path.
                mem_we     = 1'b1;
                mem_wdata  = newv_reg;
                diff_next  = newv_reg - rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = node_reg >> 1;
                node_next  = node_reg >> 1;
                state_next = ST_SET_UP;
            end
            ST_SET_UP:
            begin
                // Write this ancestor while the parent is being read.
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg + diff_reg;
                if (node_reg == NW'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = node_reg >> 1;
                    node_next = node_reg >> 1;
                end
            end
            ST_Q_LEFT:
            begin
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        mem_re       = 1'b1;
                        mem_raddr    = NW'(l_reg);
                        rd_pend_next = 1'b1;
                    end
                    state_next = ST_Q_RIGHT;
                end
                else
                begin
                    state_next = ST_Q_DONE;
                end
            end
            ST_Q_RIGHT:
            begin
                if (r_reg[0])
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = NW'(r_reg - LW'(1));
                    rd_pend_next = 1'b1;
                end
                l_next     = (l_reg + LW'(l_reg[0])) >> 1;
                r_next     = r_reg >> 1;
                state_next = ST_Q_LEFT;
            end
            ST_Q_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Channel outputs.
    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.range_sum = $signed(out_sum_reg);

`ifndef SYNTHESIS
    // A write and a read never target the same node in one cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("node memory read and write collide");

    // Query bounds never cross while the range is being walked.
    a_query_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_LEFT || state_reg == ST_Q_RIGHT) |-> (l_reg <= r_reg))
        else $error("query bounds crossed");

    // The update walk never reaches the unused node zero.
    a_set_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SET_LEAF || state_reg == ST_SET_UP) |-> (node_reg != '0))
        else $error("update walk left the tree");

    // A new result only comes from a finished query.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !rsp.ready)) |->
            $past(state_reg == ST_Q_DONE))
        else $error("result appeared without a finished query");

    // No read result is left pending when a query completes.
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_DONE) |-> !rd_pend_reg)
        else $error("query finished with a read in flight");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_segment_tree_range_sum.sv =====
// Self-checking testbench for the segment tree range-sum block.
`default_nettype none

module tb_segment_tree_range_sum;
    import strs_pkg::*;

    localparam int MAX_ELEMENTS  = DEF_MAX_ELEMENTS;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 60;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASE_ITEMS   = 325;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    strs_req_if req_ch ();
    strs_rsp_if rsp_ch ();

    segment_tree_range_sum #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Shadow copy of the element values and of the element count register.
    logic [DATA_W-1:0]        element_values [1:MAX_ELEMENTS] = '{default: '0};
    logic [COUNT_W-1:0]       element_count_shadow = COUNT_RESET;
    logic signed [DATA_W-1:0] expected_sums [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    // Clock with a period of 10 time units.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset is held low at the start and never asserted again.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Number of positions that the block actually uses.
    function automatic int active_positions();
        return (element_count_shadow > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(element_count_shadow);
    endfunction

    // Wrapped sum over the clipped inclusive range.
    function automatic logic signed [DATA_W-1:0] clipped_range_sum(
        input logic [COUNT_W-1:0] left_pos,
        input logic [COUNT_W-1:0] right_pos
    );
        int                lo;
        int                hi;
        logic [DATA_W-1:0] total;
        lo    = (left_pos < 1) ? 1 : int'(left_pos);
        hi    = (right_pos > active_positions()) ? active_positions() : int'(right_pos);
        total = '0;
        for (int p = lo; p <= hi; p++)
            total += element_values[p];
        return total;
    endfunction

    // Random 64-bit value, leaning toward the extremes and small numbers.
    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(7))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return DATA_W'($signed($urandom_range(16)) - 8);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Sends one request, with random idle cycles ahead of it, and updates the
    // prediction once it is accepted. Returns at the next falling edge with valid
    // still high so that back-to-back requests never drop valid.
    task automatic send_request(
        input logic               kind,
        input logic [COUNT_W-1:0] position,
        input logic [DATA_W-1:0]  new_value,
        input logic [COUNT_W-1:0] range_left,
        input logic [COUNT_W-1:0] range_right
    );
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.position    <= position;
        req_ch.new_value   <= new_value;
        req_ch.range_left  <= range_left;
        req_ch.range_right <= range_right;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);

        // The request was accepted at this edge.
        if (kind == KIND_QUERY)
            expected_sums.push_back(clipped_range_sum(range_left, range_right));
        else if (position >= 1 && position <= active_positions())
            element_values[position] = new_value;
        @(negedge clk);
    endtask

    task automatic set_element(input logic [COUNT_W-1:0] position, input logic [DATA_W-1:0] value);
        send_request(KIND_SET, position, value, COUNT_W'($urandom), COUNT_W'($urandom));
    endtask

    task automatic query_range(input logic [COUNT_W-1:0] left_pos, input logic [COUNT_W-1:0] right_pos);
        send_request(KIND_QUERY, COUNT_W'($urandom), {$urandom, $urandom}, left_pos, right_pos);
    endtask

    // Writes the element count once the block has gone quiet.
    task automatic write_count(input logic [COUNT_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (expected_sums.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        element_count_shadow = value;
    endtask

    // Response side: random stalls, and each result checked against the oldest expectation.
    initial
    begin
        logic signed [DATA_W-1:0] expected;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("range_sum: no result expected, actual %0d", rsp_ch.range_sum);
                    error_count++;
                end
                else
                begin
                    expected = expected_sums.pop_front();
                    if (rsp_ch.range_sum !== expected)
                    begin
                        $error("range_sum: expected %0d, actual %0d", expected, rsp_ch.range_sum);
                        error_count++;
                    end
                end
            end
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Extreme values, position and range clipping, and ignored fields at the reset count.
    task automatic test_directed_edges();
        query_range(1, 1024);
        set_element(1, {1'b0, {(DATA_W-1){1'b1}}});
        set_element(1024, {1'b1, {(DATA_W-1){1'b0}}});
        set_element(512, {DATA_W{1'b1}});
        set_element(0, 64'd77);
        set_element(1025, 64'd99);
        set_element(2047, {DATA_W{1'b1}});
        query_range(1, 1024);
        query_range(0, 2047);
        query_range(1024, 1);
        query_range(0, 0);
        query_range(1, 1);
        query_range(1024, 1024);
        query_range(512, 512);
        set_element(1, 64'd5);
        query_range(1, 1);
        set_element(513, 64'h5555_5555_5555_5555);
        send_request(KIND_SET, 11'd2, 64'hAAAA_AAAA_AAAA_AAAA, 11'h7FF, 11'h7FF);
        send_request(KIND_QUERY, 11'h7FF, {DATA_W{1'b1}}, 11'd2, 11'd1023);
        query_range(1, 2);
        query_range(513, 2047);
    endtask

    // Count of zero, one, above capacity, and a shrink that hides stored values.
    task automatic test_count_extremes();
        write_count(11'd0);
        set_element(1, 64'd11);
        query_range(0, 2047);
        query_range(1, 1);
        write_count(11'd1);
        query_range(1, 1024);
        set_element(2, 64'd123);
        set_element(1, 64'd42);
        query_range(0, 1);
        write_count(11'd2047);
        set_element(1024, 64'd1000);
        query_range(1, 2047);
        query_range(1024, 2047);
        write_count(11'd3);
        query_range(1, 2047);
        query_range(3, 1024);
        write_count(11'd1024);
        query_range(1, 1024);
        query_range(2, 1023);
    endtask

    // Random traffic at one element count and one idling mix.
    task automatic test_random_traffic(
        input int                 n_items,
        input int                 sender_idle,
        input int                 receiver_stall,
        input logic [COUNT_W-1:0] count
    );
        int                 eff;
        logic [COUNT_W-1:0] lo;
        logic [COUNT_W-1:0] hi;
        write_count(count);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        eff       = active_positions();
        for (int i = 0; i < n_items; i++)
        begin
            if (eff == 0 || $urandom_range(99) < 15)
            begin
                // Noise: any kind, any position, any range, inverted ones included.
                send_request(1'($urandom), COUNT_W'($urandom), random_value(),
                             COUNT_W'($urandom), COUNT_W'($urandom));
            end
            else if ($urandom_range(99) < 55)
            begin
                set_element(COUNT_W'($urandom_range(eff, 1)), random_value());
            end
            else
            begin
                lo = COUNT_W'($urandom_range(eff, 1));
                hi = COUNT_W'($urandom_range(eff, lo));
                query_range(lo, hi);
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_SET;
        req_ch.position    = '0;
        req_ch.new_value   = '0;
        req_ch.range_left  = '0;
        req_ch.range_right = '0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        @(posedge rst_n);
        @(negedge clk);

        test_directed_edges();
        test_count_extremes();
        test_random_traffic(PHASE_ITEMS, 0, 0, 11'd1024);
        test_random_traffic(PHASE_ITEMS, 80, 0, 11'd37);
        test_random_traffic(PHASE_ITEMS, 0, 80, 11'd2047);
        test_random_traffic(PHASE_ITEMS, 33, 33, 11'd1000);

        // Drain the outstanding results, then let the block settle.
        req_ch.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/strs_pkg.sv
design/strs_ifs.sv
design/segment_tree_range_sum.sv
tb/tb_segment_tree_range_sum.sv
